>>> design/stream_group_reverse_unit_assert.svh
// ----------------------------------------------------------------------------
// Stream group reverse assertion macros
// Shorthand for the clocked, reset-qualified checks on the reorder unit.
// ----------------------------------------------------------------------------
`ifndef STREAM_GROUP_REVERSE_UNIT_ASSERT_SVH
`define STREAM_GROUP_REVERSE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stream group reverse check failed");

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stream group reverse check failed");

`endif

>>> design/sgr_pkg.sv
// ----------------------------------------------------------------------------
// Stream group reverse package
// Item types, register width and the group descriptor shared by the unit.
// ----------------------------------------------------------------------------
package sgr_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W = 5;
	// Wide enough for a group count at the largest supported group size.
	localparam int GRP_CNT_W = 7;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic seq_end;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic out_end;
	} out_item_t;

	// One closed group waiting to be drained from its buffer bank.
	typedef struct packed {
		logic bank;
		logic [GRP_CNT_W-1:0] count;
		logic rev;
		logic last;
	} grp_desc_t;

endpackage

>>> design/sgr_front.sv
// ----------------------------------------------------------------------------
// Stream group reverse front end
// Accepts items, stores them in the fill bank and closes groups.
// ----------------------------------------------------------------------------
module sgr_front
	import sgr_pkg::*;
#(
	parameter int MAX_GROUP = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_item,
	input  logic q_full,
	output logic q_push,
	output grp_desc_t q_desc,
	output logic wr_en,
	output logic wr_bank,
	output logic [IDX_W-1:0] wr_idx,
	output logic [DATA_W-1:0] wr_data
);

	logic [CFG_W-1:0] group_size_q;
	logic [CNT_W-1:0] fill_q;
	logic bank_q;
	logic accept;
	logic [6:0] k_eff;
	logic [6:0] size_ext;
	logic [6:0] n_next;
	logic full_group;
	logic close_grp;

	// Group size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= CFG_W'(1);
		end else if (cfg_we) begin
			group_size_q <= cfg_data;
		end
	end

	// Effective group length: zero acts as one, large values saturate.
	always_comb begin
		size_ext = 7'(group_size_q);
		if (size_ext == 7'd0) begin
			k_eff = 7'd1;
		end else if (size_ext > 7'(MAX_GROUP)) begin
			k_eff = 7'(MAX_GROUP);
		end else begin
			k_eff = size_ext;
		end
	end

	// Classify the item: does it close the current group?
	always_comb begin
		in_ready = !q_full;
		accept = in_valid && in_ready;
		n_next = 7'(fill_q) + 7'd1;
		full_group = n_next >= k_eff;
		close_grp = full_group || in_item.seq_end;
		q_push = accept && close_grp;
		q_desc.bank = bank_q;
		q_desc.count = GRP_CNT_W'(n_next);
		q_desc.rev = full_group;
		q_desc.last = in_item.seq_end;
		wr_en = accept;
		wr_bank = bank_q;
		wr_idx = IDX_W'(fill_q);
		wr_data = in_item.value;
	end

	// Fill count and bank select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (close_grp) begin
				fill_q <= '0;
				bank_q <= !bank_q;
			end else begin
				fill_q <= CNT_W'(n_next);
			end
		end
	end

endmodule

>>> design/sgr_queue.sv
// ----------------------------------------------------------------------------
// Stream group reverse descriptor queue
// Two-entry queue of closed groups between the front and back ends.
// ----------------------------------------------------------------------------
module sgr_queue
	import sgr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_desc_t push_desc,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output grp_desc_t head_desc
);

	grp_desc_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	always_comb begin
		full = count_q == 2'd2;
		head_valid = count_q != 2'd0;
		head_desc = entry_q[rd_ptr_q];
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/sgr_back.sv
// ----------------------------------------------------------------------------
// Stream group reverse back end
// Holds the two-bank buffer and drains closed groups to the output.
// ----------------------------------------------------------------------------
module sgr_back
	import sgr_pkg::*;
#(
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic wr_bank,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [DATA_W-1:0] wr_data,
	input  logic head_valid,
	input  grp_desc_t head_desc,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_item
);

	localparam int DEPTH = 2 * (1 << IDX_W);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] rd_pos;
	logic at_last;
	logic issue;
	logic out_valid_q;
	out_item_t out_item_q;

	// Read order: reversed for a full group, arrival order otherwise.
	always_comb begin
		cnt = CNT_W'(head_desc.count);
		rd_pos = head_desc.rev ? (cnt - CNT_W'(1) - idx_q) : idx_q;
		at_last = idx_q == (cnt - CNT_W'(1));
		issue = head_valid && (!out_valid_q || out_ready);
		pop = issue && at_last;
		out_valid = out_valid_q;
		out_item = out_item_q;
	end

	// Buffer write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{wr_bank, wr_idx}] <= wr_data;
		end
	end

	// Buffer read port; the read register is the output register.
	always_ff @(posedge clk) begin
		if (issue) begin
			out_item_q.out_value <= mem[{head_desc.bank, IDX_W'(rd_pos)}];
			out_item_q.out_end <= head_desc.last && at_last;
		end
	end

	// Drain position and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= at_last ? '0 : idx_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/stream_group_reverse_unit.sv
// A closed group is queued; its first result is then loaded into the output register.
// Throughput: one item per cycle in and one result per cycle out while out_ready is
// high, sustained by two buffer banks, one filling while the other drains through a
// single read port. The front stalls only while both banks hold closed groups
// not yet drained. Reset clears counts, queue and output valid and sets group_size to 1;
// buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
// Stream group reverse unit
// Reverses a stream of values in groups of group_size, passing a short tail
// through in arrival order.
// ----------------------------------------------------------------------------
module stream_group_reverse_unit
	import sgr_pkg::*;
#(
	parameter int MAX_GROUP = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_item
);

	localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CNT_W = $clog2(MAX_GROUP + 1);

	logic q_full;
	logic q_push;
	grp_desc_t q_desc;
	logic q_pop;
	logic head_valid;
	grp_desc_t head_desc;
	logic wr_en;
	logic wr_bank;
	logic [IDX_W-1:0] wr_idx;
	logic [DATA_W-1:0] wr_data;

	// Front end: accept, store and close groups.
	sgr_front #(
		.MAX_GROUP(MAX_GROUP),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.q_full(q_full),
		.q_push(q_push),
		.q_desc(q_desc),
		.wr_en(wr_en),
		.wr_bank(wr_bank),
		.wr_idx(wr_idx),
		.wr_data(wr_data)
	);

	// Closed groups waiting to drain.
	sgr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_desc(q_desc),
		.full(q_full),
		.pop(q_pop),
		.head_valid(head_valid),
		.head_desc(head_desc)
	);

	// Back end: buffer and drain sequencer.
	sgr_back #(
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_bank(wr_bank),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.head_valid(head_valid),
		.head_desc(head_desc),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule

>>> design/sgr_checker.sv
// ----------------------------------------------------------------------------
// Stream group reverse checker
// Port-level checks on item accounting and output stalls.
// ----------------------------------------------------------------------------
`include "stream_group_reverse_unit_assert.svh"

module sgr_checker
	import sgr_pkg::*;
#(
	parameter int MAX_GROUP = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_item_t in_item,
	input  logic out_valid,
	input  logic out_ready,
	input  out_item_t out_item
);

	localparam int PW = $clog2(2 * MAX_GROUP + 2);

	logic in_acc;
	logic out_acc;
	logic end_in;
	logic end_out;
	logic [PW-1:0] pend_q;
	logic [PW-1:0] ends_q;

	always_comb begin
		in_acc = in_valid && in_ready;
		out_acc = out_valid && out_ready;
		end_in = in_acc && in_item.seq_end;
		end_out = out_acc && out_item.out_end;
	end

	// Items accepted but not yet delivered, and sequence ends still owed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			ends_q <= '0;
		end else begin
			pend_q <= pend_q + PW'(in_acc) - PW'(out_acc);
			ends_q <= ends_q + PW'(end_in) - PW'(end_out);
		end
	end

	// A stalled result holds its value.
	`SGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
	// No result without an item still owed.
	`SGR_ASSERT_SAME(a_no_invent, out_valid, pend_q != '0)
	// Buffering is bounded by the two banks.
	`SGR_ASSERT_SAME(a_bounded, in_acc, pend_q <= PW'(2 * MAX_GROUP))
	// A sequence end only follows an accepted sequence end.
	`SGR_ASSERT_SAME(a_end_owed, out_valid && out_item.out_end, ends_q != '0)

endmodule

bind stream_group_reverse_unit sgr_checker #(.MAX_GROUP(MAX_GROUP)) u_checker (.*);
